// ===== rtl/rmf_pkg.sv =====
// rmf_pkg: shared types, codes and helper functions for the receiver message framer.
// No dependencies. Used by rmf_cfg_regs, rmf_parser and receiver_message_framer.
`timescale 1ns / 1ps

package rmf_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_LOW  = 2'd0;
    localparam logic [1:0] CFG_MIN_HIGH = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN  = 2'd2;

    // Frame status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // Message type codes
    localparam logic [3:0] MT_GT      = 4'd0;
    localparam logic [3:0] MT_ST      = 4'd1;
    localparam logic [3:0] MT_RT      = 4'd2;
    localparam logic [3:0] MT_ET      = 4'd3;
    localparam logic [3:0] MT_PG      = 4'd4;
    localparam logic [3:0] MT_VG      = 4'd5;
    localparam logic [3:0] MT_PV      = 4'd6;
    localparam logic [3:0] MT_SG      = 4'd7;
    localparam logic [3:0] MT_DP      = 4'd8;
    localparam logic [3:0] MT_PS      = 4'd9;
    localparam logic [3:0] MT_AR      = 4'd10;
    localparam logic [3:0] MT_RE      = 4'd11;
    localparam logic [3:0] MT_ER      = 4'd12;
    localparam logic [3:0] MT_UNKNOWN = 4'd15;

    // Printable ID character range
    localparam logic [7:0] ID_CHAR_LO = 8'h21;
    localparam logic [7:0] ID_CHAR_HI = 8'h7e;

    // Configuration held by the register file
    typedef struct packed {
        logic [63:0] min_low;
        logic [23:0] min_high;
        logic [11:0] max_len;
    } rmf_cfg_t;

    // One result item
    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  data_byte;
        logic [11:0] byte_offset;
        logic        frame_end;
        logic [1:0]  frame_status;
        logic [3:0]  message_type;
    } rmf_result_t;

    function automatic logic is_id_char(input logic [7:0] b);
        return (b >= ID_CHAR_LO) && (b <= ID_CHAR_HI);
    endfunction

    // Upper-case hex digit: returns {ok, value}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= "0" && b <= "9")
        begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= "A" && b <= "F")
        begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl2(input logic [7:0] v);
        return {v[5:0], v[7:6]};
    endfunction

    function automatic logic [3:0] lookup_type(input logic [7:0] a, input logic [7:0] b);
        logic [3:0] t;
        t = MT_UNKNOWN;
        if (a == "G" && b == "T")                                 t = MT_GT;
        else if (a == "S" && b == "T")                            t = MT_ST;
        else if ((a == "~" && b == "~") || (a == "R" && b == "T")) t = MT_RT;
        else if ((a == ":" && b == ":") || (a == "E" && b == "T")) t = MT_ET;
        else if (a == "P" && b == "G")                            t = MT_PG;
        else if (a == "V" && b == "G")                            t = MT_VG;
        else if (a == "P" && b == "V")                            t = MT_PV;
        else if (a == "S" && b == "G")                            t = MT_SG;
        else if (a == "D" && b == "P")                            t = MT_DP;
        else if (a == "P" && b == "S")                            t = MT_PS;
        else if (a == "A" && b == "R")                            t = MT_AR;
        else if (a == "R" && b == "E")                            t = MT_RE;
        else if (a == "E" && b == "R")                            t = MT_ER;
        return t;
    endfunction

    // Per-type minimum body length; types without a checksum have none
    function automatic logic [7:0] lookup_min(input logic [3:0] t, input rmf_cfg_t cfg);
        logic [7:0] m;
        m = 8'd0;
        if (t < 4'd8)
        begin
            m = cfg.min_low[{t[2:0], 3'b000} +: 8];
        end
        else if (t < 4'd11)
        begin
            m = cfg.min_high[{t[1:0], 3'b000} +: 8];
        end
        return m;
    endfunction

endpackage

// ===== rtl/rmf_cfg_regs.sv =====
// rmf_cfg_regs: configuration registers (minimum length tables, max body length).
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_cfg_regs
    import rmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [63:0] wr_data,
    output rmf_cfg_t    cfg
);

    logic [63:0] min_low_reg;
    logic [23:0] min_high_reg;
    logic [11:0] max_len_reg;

    // Register writes; index 3 is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_low_reg  <= '0;
            min_high_reg <= '0;
            max_len_reg  <= 12'hfff;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_MIN_LOW:  min_low_reg  <= wr_data;
                CFG_MIN_HIGH: min_high_reg <= wr_data[23:0];
                CFG_MAX_LEN:  max_len_reg  <= wr_data[11:0];
                default:      ;
            endcase
        end
    end

    assign cfg.min_low  = min_low_reg;
    assign cfg.min_high = min_high_reg;
    assign cfg.max_len  = max_len_reg;

endmodule

// ===== rtl/rmf_parser.sv =====
// rmf_parser: frame hunting state machine; one byte per enabled cycle, at most one result.
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_parser
    import rmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  rmf_cfg_t    cfg,
    output logic        res_valid,
    output rmf_result_t res
);

    typedef enum logic [2:0] {
        PH_ID1,
        PH_ID2,
        PH_LEN1,
        PH_LEN2,
        PH_LEN3,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  id_first_reg, id_first_next;
    logic [3:0]  type_reg, type_next;
    logic [11:0] len_reg, len_next;
    logic [11:0] count_reg, count_next;
    logic [7:0]  cks_reg, cks_next;
    logic [7:0]  min_reg, min_next;

    logic        id_ok;
    logic [4:0]  hex;
    logic [11:0] len_full;
    logic [7:0]  cks_upd;
    logic [7:0]  min_lut;
    logic        known;
    logic        has_cks;
    logic        last;
    logic [12:0] count_inc;

    assign id_ok     = is_id_char(rx_byte);
    assign hex       = hex_value(rx_byte);
    assign len_full  = {len_reg[7:0], hex[3:0]};
    assign cks_upd   = rotl2(cks_reg) ^ rx_byte;
    assign min_lut   = lookup_min(type_reg, cfg);
    assign known     = (type_reg != MT_UNKNOWN);
    assign has_cks   = (type_reg <= MT_AR);
    assign count_inc = {1'b0, count_reg} + 13'd1;
    assign last      = (count_inc >= {1'b0, len_reg});

    // Next state and result for the current byte
    always_comb
    begin
        phase_next    = phase_reg;
        id_first_next = id_first_reg;
        type_next     = type_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        cks_next      = cks_reg;
        min_next      = min_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.message_type = type_reg;

        unique case (phase_reg)
            PH_ID1:
            begin
                if (id_ok)
                begin
                    id_first_next = rx_byte;
                    cks_next      = rx_byte;
                    phase_next    = PH_ID2;
                end
            end
            PH_ID2:
            begin
                if (id_ok)
                begin
                    type_next  = lookup_type(id_first_reg, rx_byte);
                    cks_next   = cks_upd;
                    phase_next = PH_LEN1;
                end
                else
                begin
                    phase_next = PH_ID1;
                end
            end
            PH_LEN1, PH_LEN2:
            begin
                if (hex[4])
                begin
                    len_next   = (phase_reg == PH_LEN1) ? {8'd0, hex[3:0]} : len_full;
                    cks_next   = cks_upd;
                    phase_next = (phase_reg == PH_LEN1) ? PH_LEN2 : PH_LEN3;
                end
                else
                begin
                    // restart; a bad byte that is an ID character opens a new ID
                    id_first_next = rx_byte;
                    cks_next      = rx_byte;
                    phase_next    = id_ok ? PH_ID2 : PH_ID1;
                end
            end
            PH_LEN3:
            begin
                if (!hex[4] || (len_full > cfg.max_len))
                begin
                    id_first_next = rx_byte;
                    cks_next      = rx_byte;
                    phase_next    = id_ok ? PH_ID2 : PH_ID1;
                end
                else
                begin
                    len_next   = len_full;
                    count_next = 12'd0;
                    cks_next   = cks_upd;
                    min_next   = min_lut;
                    if (len_full == 12'd0)
                    begin
                        // empty body closes the frame at once
                        phase_next = PH_ID1;
                        if (known)
                        begin
                            res_valid     = 1'b1;
                            res.frame_end = 1'b1;
                            if (min_lut != 8'd0)
                            begin
                                res.frame_status = ST_SHORT;
                            end
                            else if (has_cks)
                            begin
                                res.frame_status = ST_BAD;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                count_next = count_inc[11:0];
                if (has_cks && !last)
                begin
                    cks_next = cks_upd;
                end
                if (known)
                begin
                    res_valid       = 1'b1;
                    res.byte_valid  = 1'b1;
                    res.data_byte   = rx_byte;
                    res.byte_offset = count_reg;
                end
                if (last)
                begin
                    phase_next    = PH_ID1;
                    res.frame_end = known;
                    if (known)
                    begin
                        if (len_reg < {4'd0, min_reg})
                        begin
                            res.frame_status = ST_SHORT;
                        end
                        else if (has_cks && (rotl2(cks_reg) != rx_byte))
                        begin
                            res.frame_status = ST_BAD;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_ID1;
            end
        endcase
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ID1;
            id_first_reg <= '0;
            type_reg     <= MT_UNKNOWN;
            len_reg      <= '0;
            count_reg    <= '0;
            cks_reg      <= '0;
            min_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            id_first_reg <= id_first_next;
            type_reg     <= type_next;
            len_reg      <= len_next;
            count_reg    <= count_next;
            cks_reg      <= cks_next;
            min_reg      <= min_next;
        end
    end

endmodule

// ===== rtl/receiver_message_framer.sv =====
// receiver_message_framer: top level; input register, parser, result register, config port.
// Depends on rmf_pkg, rmf_cfg_regs and rmf_parser.
`timescale 1ns / 1ps
//
//  channel   handshake               payload
//  -------   ---------------------   ----------------------------------------------
//  input     in_valid / in_ready     rx_byte
//  output    out_valid / out_ready   byte_valid data_byte byte_offset frame_end
//                                    frame_status message_type
//  config    cfg_valid / cfg_ready   cfg_index cfg_data
//
//  One byte per cycle while the output is not stalled: a request is parsed while it sits in
//  the input register with step high; the output register takes its result at the next edge.
//  The rate is set by the parser state update, a single rotate-xor and compare per byte.
//  A stalled result holds the output register; an empty input register still takes one byte.
//  Async reset (rst_n low) clears the parser to hunting, valid flags and config to defaults.
//  cfg_ready is always high; writes take effect at the next edge.

module receiver_message_framer
    import rmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_valid,
    output logic [7:0]  data_byte,
    output logic [11:0] byte_offset,
    output logic        frame_end,
    output logic [1:0]  frame_status,
    output logic [3:0]  message_type,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    rmf_cfg_t    cfg;
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        out_vld_reg;
    rmf_result_t out_reg;
    logic        step;
    logic        res_valid;
    rmf_result_t res;

    assign cfg_ready = 1'b1;

    rmf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Parse when the result register is free or draining
    assign step     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || step;

    rmf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step)
        begin
            out_vld_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_vld_reg;
    assign byte_valid   = out_reg.byte_valid;
    assign data_byte    = out_reg.data_byte;
    assign byte_offset  = out_reg.byte_offset;
    assign frame_end    = out_reg.frame_end;
    assign frame_status = out_reg.frame_status;
    assign message_type = out_reg.message_type;

`ifndef SYNTH
    // Status carries meaning only on the closing result
    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_end) |-> (frame_status == ST_OK))
        else $error("frame_status set without frame_end");

    // A result without a body byte is the empty-body close
    a_empty_body_close: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (frame_end && byte_offset == 12'd0 && data_byte == 8'd0))
        else $error("result without body byte is not an empty-body close");

    // Only known types reach the output
    a_known_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (message_type <= MT_ER))
        else $error("unknown message type on output");

    // A buffered byte that is not parsed stays buffered
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !step) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("buffered input byte lost");
`endif

endmodule
